// ===== hw/rtl/lsdb_pkg.sv =====
// Shared types and constants for the link state database.
// No dependencies.
package lsdb_pkg;

    localparam int MAX_ROUTERS_DEF = 16;
    localparam int MAX_ADVS_DEF    = 8;

    localparam logic [15:0] LIFETIME_RESET = 16'd40;

    // input modes
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_HEADER = 2'd1;
    localparam logic [1:0] MODE_ADV    = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_STALE    = 2'd0;
    localparam logic [1:0] ST_STORED   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_TOO_MANY = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] router_id;
        logic [15:0] sequence_req;
        logic [7:0]  adv_count;
        logic [31:0] adv_network;
        logic [31:0] adv_mask;
        logic [31:0] adv_neighbor;
    } in_word_t;

    typedef struct packed {
        logic       changed;
        logic [1:0] status;
    } out_word_t;

endpackage

// ===== hw/rtl/link_state_database_core.sv =====
// Top level of the link state database: config register, front queue, back end.
// Depends on lsdb_pkg, lsdb_front, lsdb_back.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------
//  input    | start / busy          | in_word (in_word_t)
//  result   | result_valid strobe   | result (out_word_t)
//  config   | cfg_valid / cfg_ready | cfg_data (16 bits)
//
// A tick or header is handled in the back end by a table walk of one entry per
// cycle; an advertisement is written from the idle state without a walk.
// A two-word queue lets start be taken while the back end walks.
// Reset clears all valid bits and the fill-active flag; table data is not cleared.
// Results are strobed for one cycle; the receiver cannot stall them.
module link_state_database_core #(
    parameter int MAX_ROUTERS = lsdb_pkg::MAX_ROUTERS_DEF,
    parameter int MAX_ADVS    = lsdb_pkg::MAX_ADVS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  lsdb_pkg::in_word_t  in_word,
    output logic                result_valid,
    output lsdb_pkg::out_word_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);

    logic [15:0] lifetime_reg;
    logic        q_valid, q_pop;
    lsdb_pkg::in_word_t q_word;

    assign cfg_ready = 1'b1;

    // lifetime register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lifetime_reg <= lsdb_pkg::LIFETIME_RESET;
        else if (cfg_valid)
            lifetime_reg <= cfg_data;
    end

    lsdb_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .in_word(in_word), .busy(busy),
        .q_valid(q_valid), .q_word(q_word), .q_pop(q_pop)
    );

    lsdb_back #(.MAX_ROUTERS(MAX_ROUTERS), .MAX_ADVS(MAX_ADVS)) u_back (
        .clk(clk), .rst_n(rst_n), .lifetime(lifetime_reg), .q_valid(q_valid),
        .q_word(q_word), .q_pop(q_pop), .result_valid(result_valid), .result(result)
    );

endmodule

// ===== hw/rtl/lsdb_front.sv =====
// Front end: accepts words, drops unused modes, pushes into a two-entry queue.
// Depends on lsdb_pkg.
module lsdb_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  lsdb_pkg::in_word_t in_word,
    output logic              busy,
    output logic              q_valid,
    output lsdb_pkg::in_word_t q_word,
    input  logic              q_pop
);

    lsdb_pkg::in_word_t mem_reg [2];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic       push;
    logic       full;

    assign full    = (wr_ptr_reg[0] == rd_ptr_reg[0]) && (wr_ptr_reg[1] != rd_ptr_reg[1]);
    assign busy    = full;
    assign q_valid = (wr_ptr_reg != rd_ptr_reg);
    assign q_word  = mem_reg[rd_ptr_reg[0]];
    // unused mode is classified as nothing and never queued
    assign push    = start && !full && (in_word.mode != lsdb_pkg::MODE_NONE);

    assign wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
    assign rd_ptr_next = (q_pop && q_valid) ? rd_ptr_reg + 2'd1 : rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg[0]] <= in_word;
        end
    end

endmodule

// ===== hw/rtl/lsdb_back.sv =====
// Back end: sequential table walk for ticks and headers, advertisement writes.
// Depends on lsdb_pkg.
module lsdb_back #(
    parameter int MAX_ROUTERS = lsdb_pkg::MAX_ROUTERS_DEF,
    parameter int MAX_ADVS    = lsdb_pkg::MAX_ADVS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        lifetime,
    input  logic               q_valid,
    input  lsdb_pkg::in_word_t q_word,
    output logic               q_pop,
    output logic               result_valid,
    output lsdb_pkg::out_word_t result
);

    localparam int RW = (MAX_ROUTERS > 1) ? $clog2(MAX_ROUTERS) : 1;
    localparam int AW = (MAX_ADVS > 1) ? $clog2(MAX_ADVS) : 1;
    localparam int CW = RW + 1;
    localparam int FW = AW + 1;
    localparam int MW = (MAX_ROUTERS * MAX_ADVS > 1) ? $clog2(MAX_ROUTERS * MAX_ADVS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TICK = 2'd1;
    localparam logic [1:0] S_LOOK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // entry table
    logic        valid_reg [MAX_ROUTERS];
    logic [31:0] router_mem [MAX_ROUTERS];
    logic [15:0] seq_mem    [MAX_ROUTERS];
    logic [15:0] life_mem   [MAX_ROUTERS];
    logic [95:0] adv_mem    [MAX_ROUTERS*MAX_ADVS];

    logic [1:0]  state_reg;
    logic [CW-1:0] idx_reg;
    logic [RW-1:0] idx;
    lsdb_pkg::in_word_t cur_reg;
    logic        found_reg, free_reg;
    logic [RW-1:0] found_slot_reg, free_slot_reg;
    logic        freed_reg;
    logic        fill_active_reg;
    logic [RW-1:0] fill_slot_reg;
    logic [FW-1:0] fill_index_reg;
    logic [7:0]  fill_rem_reg;
    logic        rv_reg;
    lsdb_pkg::out_word_t res_reg;

    assign idx          = idx_reg[RW-1:0];
    assign result_valid = rv_reg;
    assign result       = res_reg;
    assign q_pop        = (state_reg == S_IDLE) && q_valid;

    logic last;
    assign last = (idx_reg == CW'(MAX_ROUTERS - 1));

    // advertisement write into the current fill slot
    logic          adv_we;
    logic [MW-1:0] adv_addr;
    assign adv_we   = (state_reg == S_IDLE) && q_valid
                      && (q_word.mode == lsdb_pkg::MODE_ADV)
                      && fill_active_reg && (fill_index_reg < FW'(MAX_ADVS));
    assign adv_addr = MW'(fill_slot_reg) * MW'(MAX_ADVS) + MW'(fill_index_reg);

    always_ff @(posedge clk)
    begin
        if (adv_we)
        begin
            adv_mem[adv_addr] <= {q_word.adv_network, q_word.adv_mask,
                                  q_word.adv_neighbor};
        end
    end

    // header decision after the walk
    logic          stale, too_many, no_room, store;
    logic [RW-1:0] slot;
    assign stale    = found_reg && (cur_reg.sequence_req <= seq_mem[found_slot_reg]);
    assign too_many = cur_reg.adv_count > 8'(MAX_ADVS);
    assign no_room  = !found_reg && !free_reg;
    assign store    = !stale && !too_many && !no_room;
    assign slot     = found_reg ? found_slot_reg : free_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rv_reg          <= 1'b0;
            fill_active_reg <= 1'b0;
            for (int i = 0; i < MAX_ROUTERS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            rv_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg   <= q_word;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        free_reg  <= 1'b0;
                        freed_reg <= 1'b0;
                        case (q_word.mode)
                            lsdb_pkg::MODE_TICK:   state_reg <= S_TICK;
                            lsdb_pkg::MODE_HEADER:
                            begin
                                state_reg       <= S_LOOK;
                                fill_active_reg <= 1'b0;
                            end
                            default:
                            begin
                                // advertisement: advance the fill
                                if (adv_we)
                                begin
                                    fill_index_reg <= fill_index_reg + FW'(1);
                                    fill_rem_reg   <= fill_rem_reg - 8'd1;
                                    if (fill_rem_reg <= 8'd1)
                                    begin
                                        fill_active_reg <= 1'b0;
                                    end
                                end
                                else
                                begin
                                    fill_active_reg <= 1'b0;
                                end
                            end
                        endcase
                    end
                end
                // one entry per cycle
                S_TICK:
                begin
                    if (valid_reg[idx])
                    begin
                        if (life_mem[idx] <= 16'd1)
                        begin
                            valid_reg[idx] <= 1'b0;
                            freed_reg      <= 1'b1;
                            if (fill_active_reg && fill_slot_reg == idx)
                            begin
                                fill_active_reg <= 1'b0;
                            end
                        end
                        else
                        begin
                            life_mem[idx] <= life_mem[idx] - 16'd1;
                        end
                    end
                    idx_reg <= idx_reg + CW'(1);
                    if (last)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_LOOK:
                begin
                    if (valid_reg[idx] && router_mem[idx] == cur_reg.router_id
                        && !found_reg)
                    begin
                        found_reg      <= 1'b1;
                        found_slot_reg <= idx;
                    end
                    if (!valid_reg[idx] && !free_reg)
                    begin
                        free_reg      <= 1'b1;
                        free_slot_reg <= idx;
                    end
                    idx_reg <= idx_reg + CW'(1);
                    if (last)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    rv_reg    <= 1'b1;
                    if (cur_reg.mode == lsdb_pkg::MODE_TICK)
                    begin
                        res_reg.changed <= freed_reg;
                        res_reg.status  <= lsdb_pkg::ST_STALE;
                    end
                    else
                    begin
                        res_reg.changed <= store;
                        if (stale)
                            res_reg.status <= lsdb_pkg::ST_STALE;
                        else if (too_many)
                            res_reg.status <= lsdb_pkg::ST_TOO_MANY;
                        else if (no_room)
                            res_reg.status <= lsdb_pkg::ST_FULL;
                        else
                            res_reg.status <= lsdb_pkg::ST_STORED;
                        if (store)
                        begin
                            valid_reg[slot]  <= 1'b1;
                            router_mem[slot] <= cur_reg.router_id;
                            seq_mem[slot]    <= cur_reg.sequence_req;
                            life_mem[slot]   <= lifetime;
                            fill_slot_reg    <= slot;
                            fill_index_reg   <= '0;
                            fill_rem_reg     <= cur_reg.adv_count;
                            fill_active_reg  <= (cur_reg.adv_count != 8'd0);
                        end
                    end
                end
            endcase
        end
    end

endmodule
